FILE: design/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// shared constants, types and command/status structs for the peak summariser
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned MaxChannels     = 8;
  localparam int unsigned MaxBucketFrames = 4096;
  localparam int unsigned SampleBits      = 24;

  localparam int unsigned ChBits    = 3;
  localparam int unsigned CountBits = 13;
  localparam int unsigned IdxBits   = 24;
  localparam int unsigned SumBits   = 59;
  localparam int unsigned SqBits    = 48;
  localparam int unsigned QuotBits  = 48;

  localparam logic [0:0] RegSamplesPerPeak = 1'b0;
  localparam logic [0:0] RegNumChannels    = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StAccum,
    StDivide,
    StSqrt,
    StOutput
  } wps_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
  } wps_cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic sqrt_done;
  } wps_status_t;

endpackage

FILE: design/wps_datapath.sv
// ----------------------------------------------------------------------------
// wps_datapath
// per-channel accumulators, shared counters, serial divider and square root
// ----------------------------------------------------------------------------
module wps_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wps_pkg::wps_cmd_t                      cmd_i,
  output wps_pkg::wps_status_t                   status_o,
  input  logic                                   cfg_valid_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [15:0]                            cfg_data_i,
  input  logic signed [wps_pkg::SampleBits-1:0]  sample_i,
  input  logic                                   end_of_clip_i,
  output logic [wps_pkg::ChBits-1:0]             channel_o,
  output logic [wps_pkg::IdxBits-1:0]            peak_index_o,
  output logic signed [wps_pkg::SampleBits-1:0]  min_value_o,
  output logic signed [wps_pkg::SampleBits-1:0]  max_value_o,
  output logic [wps_pkg::SampleBits-1:0]         rms_value_o,
  output logic [wps_pkg::CountBits-1:0]          frame_count_o,
  output logic                                   last_o
);
  import wps_pkg::*;

  logic [CountBits-1:0] spp_q;
  logic [3:0]           nch_q;
  logic [CountBits-1:0] frames_q;
  logic [ChBits-1:0]    pos_q;
  logic [IdxBits-1:0]   bucket_q;

  logic signed [SampleBits-1:0] min_mem [MaxChannels];
  logic signed [SampleBits-1:0] max_mem [MaxChannels];
  logic [SumBits-1:0]           sum_mem [MaxChannels];

  // captured sample
  logic signed [SampleBits-1:0] smp_q;
  logic                         eoc_q;
  logic [SqBits-1:0]            sq_q;

  logic [CountBits-1:0] spp_eff, count;
  logic [3:0]           nch_eff;
  logic [ChBits-1:0]    ch;
  logic                 last_ch, close;
  logic [SampleBits-1:0] mag;
  logic signed [SampleBits-1:0] new_min, new_max;
  logic [SumBits-1:0]   new_sum;

  always_comb begin
    spp_eff = spp_q;
    if (spp_q == '0) spp_eff = CountBits'(1);
    if (spp_q > CountBits'(MaxBucketFrames)) spp_eff = CountBits'(MaxBucketFrames);
    nch_eff = nch_q;
    if (nch_q == '0) nch_eff = 4'd1;
    if (nch_q > 4'(MaxChannels)) nch_eff = 4'(MaxChannels);
    ch      = ({1'b0, pos_q} >= nch_eff) ? '0 : pos_q;
    count   = frames_q + CountBits'(1);
    last_ch = ({1'b0, ch} + 4'd1) >= nch_eff;
    close   = (count >= spp_eff) || eoc_q;
    if (frames_q == '0) begin
      new_min = smp_q;
      new_max = smp_q;
      new_sum = SumBits'(sq_q);
    end else begin
      new_min = (smp_q < min_mem[ch]) ? smp_q : min_mem[ch];
      new_max = (smp_q > max_mem[ch]) ? smp_q : max_mem[ch];
      new_sum = sum_mem[ch] + SumBits'(sq_q);
    end
  end

  assign mag = smp_q[SampleBits-1] ? SampleBits'(-smp_q) : smp_q;
  assign status_o.close = close;

  // square the magnitude in the capture cycle after load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= sample_i;
      eoc_q <= end_of_clip_i;
    end
    sq_q <= SqBits'(mag) * SqBits'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      min_mem[ch] <= new_min;
      max_mem[ch] <= new_max;
      sum_mem[ch] <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q    <= CountBits'(256);
      nch_q    <= 4'd2;
      frames_q <= '0;
      pos_q    <= '0;
      bucket_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegSamplesPerPeak: spp_q <= cfg_data_i[CountBits-1:0];
          RegNumChannels:    nch_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.div_start) begin
        if (last_ch) begin
          pos_q <= '0;
          if (eoc_q) begin
            frames_q <= '0;
            bucket_q <= '0;
          end else if (count >= spp_eff) begin
            frames_q <= '0;
            if (bucket_q != '1) bucket_q <= bucket_q + IdxBits'(1);
          end else begin
            frames_q <= count;
          end
        end else begin
          pos_q <= ch + ChBits'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SumBits-1:0]   rem_q;
  logic [QuotBits-1:0]  quot_q;
  logic [CountBits-1:0] dsr_q;
  logic [5:0]           dcnt_q;
  logic [CountBits:0]   rtrial;
  logic [SumBits-1:0]   rem_sh;

  assign rem_sh = {rem_q[SumBits-2:0], quot_q[QuotBits-1]};
  // remainder always below divisor, so only the low bits matter for the trial
  assign rtrial = {rem_q[CountBits-1:0], quot_q[QuotBits-1]};

  // quotient of a 59-bit sum by count always fits 48 bits, as the sum is at most count times 2^46
  logic [SumBits-1:0] dividend_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dividend_q <= new_sum;
      rem_q      <= SumBits'(new_sum[SumBits-1:QuotBits]);
      quot_q     <= new_sum[QuotBits-1:0];
      dsr_q      <= count;
      dcnt_q     <= 6'(QuotBits);
      channel_o     <= ch;
      peak_index_o  <= bucket_q;
      min_value_o   <= new_min;
      max_value_o   <= new_max;
      frame_count_o <= count;
      last_o        <= eoc_q && last_ch;
    end else if (cmd_i.div_step) begin
      if (rtrial >= {1'b0, dsr_q}) begin
        rem_q  <= SumBits'(rtrial - {1'b0, dsr_q});
        quot_q <= {quot_q[QuotBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[QuotBits-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
    end
  end
  assign status_o.div_done = (dcnt_q == '0);

  // bitwise integer square root, one result bit a cycle
  logic [SumBits-1:0] sx_q, sres_q, sbit_q, strial;
  logic [SumBits-1:0] radicand;
  assign radicand = (dsr_q == CountBits'(1)) ? dividend_q : SumBits'(quot_q);
  assign strial   = sres_q + sbit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sx_q   <= radicand;
      sres_q <= '0;
      sbit_q <= SumBits'(1) << (SumBits - 1);
    end else if (cmd_i.sqrt_step) begin
      if (sx_q >= strial) begin
        sx_q   <= sx_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end
  // 59-bit start bit is even position 58, so the bit reaches zero cleanly
  assign status_o.sqrt_done = (sbit_q == '0);
  assign rms_value_o = sres_q[SampleBits-1:0];

endmodule

FILE: design/wps_controller.sv
// ----------------------------------------------------------------------------
// wps_controller
// sequences capture, update, division, square root and result hand-off
// ----------------------------------------------------------------------------
module wps_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wps_pkg::wps_cmd_t    cmd_o,
  input  wps_pkg::wps_status_t status_i
);
  import wps_pkg::*;

  wps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StSquare;
      // square of the captured sample lands at the end of this cycle
      StSquare: state_d = StAccum;
      StAccum:  state_d = status_i.close ? StDivide : StIdle;
      StDivide: if (status_i.div_done) state_d = StSqrt;
      StSqrt:   if (status_i.sqrt_done) state_d = StOutput;
      StOutput: if (out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StSquare: ;
      StAccum:  cmd_o.div_start = 1'b1;
      StDivide: begin
        cmd_o.div_step   = !status_i.div_done;
        cmd_o.sqrt_start = status_i.div_done;
      end
      StSqrt:   cmd_o.sqrt_step = !status_i.sqrt_done;
      StOutput: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: design/waveform_peak_summarizer_unit.sv
// ----------------------------------------------------------------------------
// waveform_peak_summarizer_unit
// per-channel min, max and rms decimation of interleaved audio samples
// ----------------------------------------------------------------------------
// usage:
//   samples enter on the in channel (sample_i, end_of_clip_i), channels
//   interleaved in frame order. one request is taken at a time.
//   a sample that does not close its channel's bucket passes through capture,
//   square and update before the next request is accepted.
//   a closing sample runs a serial divide (48 quotient steps) and a serial
//   square root (30 steps) before out_valid_o rises; the next request is
//   taken the cycle after the peak request is accepted.
//   the peak request is held on the out ports until out_ready_i; while the
//   receiver stalls no new sample is taken.
//   configuration writes take effect from the next cycle; cfg_ready_o is always high.
//   reset clears the frame, channel and bucket counters and loads
//   samples_per_peak 256 and num_channels 2; accumulators need no clearing
//   since the first frame of a bucket loads them.
// ----------------------------------------------------------------------------
module waveform_peak_summarizer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [0:0]                            cfg_index_i,
  input  logic [15:0]                           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [wps_pkg::SampleBits-1:0] sample_i,
  input  logic                                  end_of_clip_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wps_pkg::ChBits-1:0]            channel_o,
  output logic [wps_pkg::IdxBits-1:0]           peak_index_o,
  output logic signed [wps_pkg::SampleBits-1:0] min_value_o,
  output logic signed [wps_pkg::SampleBits-1:0] max_value_o,
  output logic [wps_pkg::SampleBits-1:0]        rms_value_o,
  output logic [wps_pkg::CountBits-1:0]         frame_count_o,
  output logic                                  last_o
);
  import wps_pkg::*;

  wps_cmd_t    cmd;
  wps_status_t status;

  // config always accepted
  assign cfg_ready_o = 1'b1;

  wps_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .status_i(status)
  );

  wps_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i, .sample_i, .end_of_clip_i,
    .channel_o, .peak_index_o, .min_value_o, .max_value_o, .rms_value_o,
    .frame_count_o, .last_o
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the waveform peak summariser: directed corner
// samples, then randomised clips over many register settings, checked
// against an in-bench predictor of min, max, rms and bucket bookkeeping
// ----------------------------------------------------------------------------
module testbench;

  // one peak entry as seen on the out ports
  typedef struct packed {
    logic [2:0]         channel;
    logic [23:0]        peak_index;
    logic signed [23:0] min_value;
    logic signed [23:0] max_value;
    logic [23:0]        rms_value;
    logic [12:0]        frame_count;
    logic               last;
  } peak_t;

  // predicts peak entries from accepted samples and checks returned ones
  class peak_scoreboard;
    bit [12:0]          spp_reg = 13'd256;
    bit [3:0]           nch_reg = 4'd2;
    logic signed [23:0] run_min[8];
    logic signed [23:0] run_max[8];
    bit [63:0]          sq_sum[8];
    int unsigned        frames = 0;
    int unsigned        ch_pos = 0;
    bit [23:0]          bucket = 0;
    peak_t              pending[$];
    int unsigned        errors = 0;
    int unsigned        checked = 0;

    function void write_reg(bit idx, bit [15:0] data);
      if (idx == wps_pkg::RegSamplesPerPeak) spp_reg = data[12:0];
      else nch_reg = data[3:0];
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_sample(logic signed [23:0] s, bit eoc);
      int unsigned spp;
      int unsigned nch;
      int unsigned ch;
      int unsigned cnt;
      longint      sv;
      bit [63:0]   mag;
      bit          last_ch;
      peak_t       p;
      spp = spp_reg;
      nch = nch_reg;
      if (spp == 0) spp = 1;
      if (spp > 4096) spp = 4096;
      if (nch == 0) nch = 1;
      if (nch > 8) nch = 8;
      // channel count lowered mid-frame restarts the frame
      if (ch_pos >= nch) ch_pos = 0;
      ch = ch_pos;
      sv = s;
      mag = (sv < 0) ? -sv : sv;
      if (frames == 0) begin
        run_min[ch] = s;
        run_max[ch] = s;
        sq_sum[ch] = mag * mag;
      end else begin
        if (s < run_min[ch]) run_min[ch] = s;
        if (s > run_max[ch]) run_max[ch] = s;
        sq_sum[ch] = sq_sum[ch] + mag * mag;
      end
      cnt = frames + 1;
      last_ch = (ch + 1 >= nch);
      if (cnt >= spp || eoc) begin
        p.channel     = ch[2:0];
        p.peak_index  = bucket;
        p.min_value   = run_min[ch];
        p.max_value   = run_max[ch];
        p.rms_value   = 24'(floor_sqrt(sq_sum[ch] / cnt));
        p.frame_count = cnt[12:0];
        p.last        = eoc && last_ch;
        pending.push_back(p);
      end
      if (last_ch) begin
        ch_pos = 0;
        if (eoc) begin
          frames = 0;
          bucket = 0;
        end else if (cnt >= spp) begin
          frames = 0;
          if (bucket != 24'hFFFFFF) bucket = bucket + 1;
        end else begin
          frames = cnt;
        end
      end else begin
        ch_pos = ch + 1;
      end
    endfunction

    function void cmp_field(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_peak(peak_t got);
      peak_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected peak on channel %0d, expected none, actual index %0d",
                 $time, got.channel, got.peak_index);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp_field("channel", e.channel, got.channel);
      cmp_field("peak_index", e.peak_index, got.peak_index);
      cmp_field("min_value", e.min_value, got.min_value);
      cmp_field("max_value", e.max_value, got.max_value);
      cmp_field("rms_value", e.rms_value, got.rms_value);
      cmp_field("frame_count", e.frame_count, got.frame_count);
      cmp_field("last", e.last, got.last);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] sample_i = '0;
  logic               end_of_clip_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         channel_o;
  logic [23:0]        peak_index_o;
  logic signed [23:0] min_value_o;
  logic signed [23:0] max_value_o;
  logic [23:0]        rms_value_o;
  logic [12:0]        frame_count_o;
  logic               last_o;

  peak_scoreboard sb = new;

  // run control shared between the stimulus and the receiver
  bit          calm = 1'b0;       // no idling on either side
  bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
  int unsigned samples_sent = 0;
  int unsigned settings_used = 0;

  always #5 clk_i = ~clk_i;

  waveform_peak_summarizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .end_of_clip_i (end_of_clip_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .peak_index_o  (peak_index_o),
    .min_value_o   (min_value_o),
    .max_value_o   (max_value_o),
    .rms_value_o   (rms_value_o),
    .frame_count_o (frame_count_o),
    .last_o        (last_o)
  );

  // receiver: random stall bursts, one long hold-off on request
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else if (hold_req) begin
      // long stretch so the block fills up and stalls its input
      hold_req = 1'b0;
      hold_left = 400;
      out_ready_i = 1'b0;
    end else if (!calm && stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // peak monitor, sampled at the rising edge before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_peak('{channel_o, peak_index_o, min_value_o, max_value_o,
                      rms_value_o, frame_count_o, last_o});
    end
  end

  // offer one sample request, with an optional gap first
  task automatic send_sample(logic signed [23:0] s, bit eoc, bit gaps);
    int unsigned gap;
    @(negedge clk_i);
    gap = (gaps && !calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i = s;
    end_of_clip_i = eoc;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_sample(s, eoc);
    samples_sent++;
  endtask

  // sender pause: every expected peak back, then let the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, bit [15:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(int unsigned spp, int unsigned nch);
    write_reg(wps_pkg::RegSamplesPerPeak, {3'($urandom), 13'(spp)});
    write_reg(wps_pkg::RegNumChannels, {12'($urandom), 4'(nch)});
    settings_used++;
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return -24'sh800000;
      2:       return 24'($signed($urandom_range(0, 15)) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  // one randomised setting with a few clips, ending on a full final frame
  task automatic random_phase(bit gaps);
    int unsigned spp;
    int unsigned nch;
    int unsigned eff_spp;
    int unsigned eff_nch;
    int unsigned nframes;
    int unsigned max_frames;
    case ($urandom_range(0, 19))
      0:       spp = 0;
      1:       spp = 4096;
      2:       spp = $urandom_range(4097, 8191);
      3, 4, 5: spp = $urandom_range(9, 40);
      default: spp = $urandom_range(1, 8);
    endcase
    nch = $urandom_range(0, 15);
    set_config(spp, nch);
    eff_spp = (spp == 0) ? 1 : (spp > 4096 ? 4096 : spp);
    eff_nch = (nch == 0) ? 1 : (nch > 8 ? 8 : nch);
    // keep one clip to about 96 samples
    max_frames = 96 / eff_nch;
    if (3 * eff_spp < max_frames) max_frames = 3 * eff_spp;
    repeat ($urandom_range(1, 3)) begin
      if (samples_sent >= 1500) break;
      nframes = (eff_spp > 64) ? $urandom_range(1, 5) : $urandom_range(1, max_frames);
      for (int f = 0; f < nframes; f++) begin
        for (int c = 0; c < eff_nch; c++) begin
          // a stray clip-end flag now and then closes one channel early
          if (f == nframes - 1) send_sample(pick_sample(), 1'b1, gaps);
          else send_sample(pick_sample(), $urandom_range(0, 29) == 0, gaps);
        end
      end
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: two channels, extremes, clip end on the second frame
    send_sample(24'sh7FFFFF, 1'b0, 1'b0);
    send_sample(-24'sh800000, 1'b0, 1'b0);
    send_sample(-24'sh800000, 1'b1, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1, 1'b0);

    // one frame per bucket, one channel, upper data bits set
    write_reg(wps_pkg::RegSamplesPerPeak, 16'hE001);
    write_reg(wps_pkg::RegNumChannels, 16'hFFF1);
    send_sample(24'sh000000, 1'b0, 1'b0);
    send_sample(-24'sh000001, 1'b0, 1'b0);
    send_sample(-24'sh800000, 1'b1, 1'b0);

    // register values out of range: zero frames and fifteen channels
    set_config(0, 15);
    for (int c = 0; c < 8; c++) send_sample(pick_sample(), 1'b0, 1'b0);

    // bucket length above the limit, a stray clip-end flag on channel 1, clip end on channel 2
    set_config(8191, 3);
    send_sample(24'sh123456, 1'b0, 1'b0);
    send_sample(-24'sh654321, 1'b1, 1'b0);
    send_sample(24'sh000007, 1'b0, 1'b0);
    send_sample(-24'sh000001, 1'b0, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0, 1'b0);
    send_sample(-24'sh800000, 1'b1, 1'b0);

    // bucket shortened mid-bucket, then channel count lowered mid-frame
    set_config(8, 2);
    repeat (4) send_sample(pick_sample(), 1'b0, 1'b0);
    write_reg(wps_pkg::RegSamplesPerPeak, 16'd2);
    send_sample(pick_sample(), 1'b0, 1'b0);
    write_reg(wps_pkg::RegNumChannels, 16'd1);
    send_sample(pick_sample(), 1'b1, 1'b0);

    // randomised clips over many settings
    phase = 0;
    while (samples_sent < 1500) begin
      if (phase == 3) hold_req = 1'b1;
      if (samples_sent > 1350) calm = 1'b1;
      random_phase($urandom_range(0, 3) != 0);
      phase++;
    end

    wait_idle();
    $display("%0d samples sent, %0d peak entries checked across %0d register settings",
             samples_sent, sb.checked, settings_used);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule
